// File: design/swmd_pkg.sv
package swmd_pkg;

  localparam int NUM_DIGITS = 4;
  localparam int SEL_W      = $clog2(NUM_DIGITS);
  localparam int CNT_W      = 8;
  localparam int SEG_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  localparam logic [CNT_W-1:0] PRESCALE_LAST_RST = 8'd9;
  localparam logic [CNT_W-1:0] MUX_LAST_RST      = 8'd5;

  localparam logic [SEL_W-1:0] DP_DIGIT = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESCALE_LAST = 1'b0,
    REG_MUX_LAST      = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0] prescale_last;
    logic [CNT_W-1:0] mux_last;
  } cfg_t;

  typedef struct packed {
    logic             decimal_point;
    logic [SEG_W-1:0] segments;
    logic [SEL_W-1:0] digit_select;
  } result_t;

  function automatic logic [SEG_W-1:0] seg_decode(input logic [3:0] value);
    logic [SEG_W-1:0] seg;
    case (value)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7C;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h67;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

// File: design/swmd_core.sv
module swmd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tick,
  input  logic              start_stop_press,
  input  logic              clear_level,
  input  swmd_pkg::cfg_t    cfg,
  output swmd_pkg::result_t result
);

  logic                        running_r, running_nxt;
  logic [swmd_pkg::CNT_W-1:0]  prescale_count_r, prescale_count_nxt;
  logic [swmd_pkg::CNT_W-1:0]  mux_count_r, mux_count_nxt;
  logic [swmd_pkg::SEL_W-1:0]  digit_index_r, digit_index_nxt;
  logic [3:0]                  hundredths_r, hundredths_nxt;
  logic [3:0]                  tenths_r, tenths_nxt;
  logic [3:0]                  seconds_units_r, seconds_units_nxt;
  logic [2:0]                  seconds_tens_r, seconds_tens_nxt;
  logic [3:0]                  sel_value;

  always_comb begin
    running_nxt        = running_r ^ start_stop_press;
    prescale_count_nxt = prescale_count_r;
    hundredths_nxt     = hundredths_r;
    tenths_nxt         = tenths_r;
    seconds_units_nxt  = seconds_units_r;
    seconds_tens_nxt   = seconds_tens_r;

    if (mux_count_r >= cfg.mux_last) begin
      mux_count_nxt = '0;
      if (digit_index_r == swmd_pkg::SEL_W'(swmd_pkg::NUM_DIGITS - 1)) begin
        digit_index_nxt = '0;
      end else begin
        digit_index_nxt = digit_index_r + 1'b1;
      end
    end else begin
      mux_count_nxt   = mux_count_r + 1'b1;
      digit_index_nxt = digit_index_r;
    end

    if (running_nxt) begin
      if (prescale_count_r >= cfg.prescale_last) begin
        prescale_count_nxt = '0;
        if (hundredths_r != 4'd9) begin
          hundredths_nxt = hundredths_r + 1'b1;
        end else begin
          hundredths_nxt = '0;
          if (tenths_r != 4'd9) begin
            tenths_nxt = tenths_r + 1'b1;
          end else begin
            tenths_nxt = '0;
            if (seconds_units_r != 4'd9) begin
              seconds_units_nxt = seconds_units_r + 1'b1;
            end else begin
              seconds_units_nxt = '0;
              seconds_tens_nxt  = (seconds_tens_r >= 3'd5) ? 3'd0 : seconds_tens_r + 1'b1;
            end
          end
        end
      end else begin
        prescale_count_nxt = prescale_count_r + 1'b1;
      end
    end else if (clear_level) begin
      hundredths_nxt    = '0;
      tenths_nxt        = '0;
      seconds_units_nxt = '0;
      seconds_tens_nxt  = '0;
    end
  end

  always_comb begin
    case (digit_index_nxt)
      2'd0:    sel_value = hundredths_r;
      2'd1:    sel_value = tenths_r;
      2'd2:    sel_value = seconds_units_r;
      default: sel_value = {1'b0, seconds_tens_r};
    endcase
    result.digit_select  = digit_index_nxt;
    result.segments      = swmd_pkg::seg_decode(sel_value);
    result.decimal_point = (digit_index_nxt == swmd_pkg::DP_DIGIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r        <= 1'b0;
      prescale_count_r <= '0;
      mux_count_r      <= '0;
      digit_index_r    <= '0;
      hundredths_r     <= '0;
      tenths_r         <= '0;
      seconds_units_r  <= '0;
      seconds_tens_r   <= '0;
    end else if (tick) begin
      running_r        <= running_nxt;
      prescale_count_r <= prescale_count_nxt;
      mux_count_r      <= mux_count_nxt;
      digit_index_r    <= digit_index_nxt;
      hundredths_r     <= hundredths_nxt;
      tenths_r         <= tenths_nxt;
      seconds_units_r  <= seconds_units_nxt;
      seconds_tens_r   <= seconds_tens_nxt;
    end
  end

endmodule

// File: design/swmd_cfg.sv
module swmd_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [swmd_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [swmd_pkg::CNT_W-1:0]    wr_data,
  output swmd_pkg::cfg_t                cfg
);

  swmd_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (swmd_pkg::cfg_reg_t'(wr_index))
        swmd_pkg::REG_PRESCALE_LAST: cfg_nxt.prescale_last = wr_data;
        swmd_pkg::REG_MUX_LAST:      cfg_nxt.mux_last      = wr_data;
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prescale_last <= swmd_pkg::PRESCALE_LAST_RST;
      cfg_r.mux_last      <= swmd_pkg::MUX_LAST_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: design/swmd_obuf.sv
module swmd_obuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  swmd_pkg::result_t push_data,
  output logic              push_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output swmd_pkg::result_t out_data
);

  logic              main_v_r, main_v_nxt;
  logic              skid_v_r, skid_v_nxt;
  swmd_pkg::result_t main_r, main_nxt;
  swmd_pkg::result_t skid_r, skid_nxt;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (!main_v_r || out_ready) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        main_v_nxt = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        main_nxt   = push_data;
        main_v_nxt = push;
      end
    end else if (push) begin
      skid_nxt   = push_data;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign push_ready = !skid_v_r;
  assign out_valid  = main_v_r;
  assign out_data   = main_r;

endmodule

// File: design/stopwatch_mux_display.sv
// Four-digit multiplexed seven-segment stopwatch, one word per millisecond tick.
// Input stream: one word per tick; tdata bit0 start/stop press (toggles run),
//   bit1 clear button level (zeroes the digits while stopped).
// Output stream: one word per input word; tdata carries the digit select,
//   its segment pattern (bit0 = a .. bit6 = g) and the decimal point (digit 2).
// Config channel: index 0 prescale_last (ticks per hundredth - 1, reset 9),
//   index 1 mux_last (ticks per digit - 1, reset 5); cfg_ready is always high,
//   write only while no word is in flight.
// Each accepted word's result is registered in the output register (or the skid
//   entry while stalled) before it shows on out_tvalid. Throughput: one word per
//   cycle while in_tready is high, set by the single counter-to-output state update.
// A two-entry output buffer (output register plus skid) lets in_tready stay
//   high while one result waits; in_tready drops only when both hold results
//   and recovers the cycle after the receiver takes one.
// Reset (rst_n low at a clock edge): stopped, all counters and digits zero,
//   output buffer empty, registers back to their reset values.
module stopwatch_mux_display (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [swmd_pkg::IN_DATA_W-1:0]  in_tdata,  // [0] start_stop_press, [1] clear_level
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [swmd_pkg::OUT_DATA_W-1:0] out_tdata, // [1:0] digit_select, [8:2] segments,
                                                     // [9] decimal_point
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swmd_pkg::CNT_W-1:0]      cfg_data
);

  logic              tick;
  swmd_pkg::cfg_t    cfg;
  swmd_pkg::result_t core_res;
  swmd_pkg::result_t out_res;

  assign cfg_ready = 1'b1;
  assign tick      = in_tvalid && in_tready;

  swmd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  swmd_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .tick             (tick),
    .start_stop_press (in_tdata[0]),
    .clear_level      (in_tdata[1]),
    .cfg              (cfg),
    .result           (core_res)
  );

  swmd_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (tick),
    .push_data  (core_res),
    .push_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res)
  );

  assign out_tdata = {{(swmd_pkg::OUT_DATA_W - $bits(swmd_pkg::result_t)){1'b0}}, out_res};

endmodule

// File: design/swmd_chk.sv
module swmd_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [swmd_pkg::OUT_DATA_W-1:0] out_tdata
);

  a_dp_matches_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[9] == (out_tdata[1:0] == swmd_pkg::DP_DIGIT)))
    else $error("decimal point does not follow digit select");

  a_seg_nonblank: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[8:2] != '0))
    else $error("blank segment pattern on a valid word");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("output word changed while stalled");

  a_accept_yields_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> out_tvalid)
    else $error("accepted word produced no output");

endmodule

bind stopwatch_mux_display swmd_chk u_swmd_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
